// ----- hdl/bfws_pkg.sv -----
// Package for the box filter window sum block.
// Holds sizes, register indexes and the controller-to-datapath command types.
// No dependencies.
package bfws_pkg;

    localparam int MAX_LINE = 1024;
    localparam int MAX_BOX = 16;
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int SLOT_W = $clog2(MAX_BOX);
    localparam int ROW_W = 13;
    localparam int BOX_W = 5;
    localparam int PIX_W = 16;
    localparam int CS_W = 20;
    localparam int SUM_W = 24;

    localparam logic [1:0] REG_OUT_WIDTH = 2'd0;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BOX_SIZE = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    typedef struct packed {
        logic             load;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] x;
        logic [SLOT_W-1:0] slot;
        logic             first_row;
        logic             in_box_rows;
        logic             first_col;
        logic             in_box_cols;
        logic [COL_W-1:0] x_back;
        logic             restart;
    } bfws_cmd_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic             scale;
        logic [BOX_W-1:0] box;
    } bfws_tag_t;

endpackage

// ----- hdl/box_filter_window_sum_top.sv -----
// Box filter window sum: source pixels in, window sums out.
// Usage: program out_width, out_height, box_size and scale_enable through the
// cfg port while idle; any write restarts the frame. Stream the source frame of
// (out_width+box_size-1) by (out_height+box_size-1) pixels in raster order on
// the s_ channel, one pixel per transfer. For each pixel that completes a full
// window, one transfer appears on the m_ channel with the window sum, or the
// sum divided by box_size squared when scaling; tlast marks the frame's last.
// One pixel is handled at a time. A pixel that completes no window allows the
// next transfer once the row store and column sum memory read-modify-write
// pipeline has drained. Without scaling the window sum goes from that pipeline
// to the output register; with scaling the bit-serial divider comes between
// them, and the next transfer waits for the quotient. A stalled receiver holds
// the result and s_tready stays low until it is taken.
// Reset (synchronous, active low) restores defaults and restarts the frame.
// Depends on bfws_pkg, bfws_ctrl, bfws_datapath.
module box_filter_window_sum_top
    import bfws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // box_value
    output logic        m_tlast
);
    bfws_cmd_t cmd;
    bfws_tag_t tag;
    logic      dp_busy;

    bfws_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_pixel(s_tdata),
        .s_tready(s_tready),
        .dp_busy(dp_busy),
        .cmd(cmd),
        .tag(tag)
    );

    bfws_datapath u_dp (
        .aclk(aclk),
        .aresetn(aresetn),
        .cmd(cmd),
        .tag(tag),
        .m_tready(m_tready),
        .busy(dp_busy),
        .m_tvalid(m_tvalid),
        .m_value(m_tdata),
        .m_last(m_tlast)
    );
endmodule

// ----- hdl/bfws_divider.sv -----
// Restoring divider: window sum divided by box_size squared, one bit per cycle.
// Depends on bfws_pkg.
module bfws_divider
    import bfws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [BOX_W-1:0] box,
    output logic             busy,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [SUM_W:0]   rem_reg, rem_next;
    logic [9:0]       dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [SUM_W:0]   trial;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[SUM_W-1:0], quo_reg[SUM_W-1]};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            if (trial >= {{(SUM_W-9){1'b0}}, dsr_reg}) begin
                rem_next = trial - {{(SUM_W-9){1'b0}}, dsr_reg};
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= 10'(box) * 10'(box);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- hdl/bfws_datapath.sv -----
// Datapath: row store, column sum memory, running window sum, output register.
// Depends on bfws_pkg and bfws_divider.
module bfws_datapath
    import bfws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  bfws_cmd_t        cmd,
    input  bfws_tag_t        tag,
    input  logic             m_tready,
    output logic             busy,
    output logic             m_tvalid,
    output logic [SUM_W-1:0] m_value,
    output logic             m_last
);
    logic [PIX_W-1:0] row_mem [MAX_BOX*MAX_LINE];
    logic [CS_W-1:0]  col_mem [MAX_LINE];

    // Stage 1: memory reads.
    logic [PIX_W-1:0] old_pix_reg;
    logic [CS_W-1:0]  cs_rd_reg, back_rd_reg;
    bfws_cmd_t        c1_reg;
    bfws_tag_t        t1_reg;
    logic             v1_reg;
    // Stage 2: new column sum written.
    logic [CS_W-1:0]  cs_reg;
    bfws_cmd_t        c2_reg;
    bfws_tag_t        t2_reg;
    logic             v2_reg;
    logic [CS_W-1:0]  cs_next;
    logic [SUM_W-1:0] win_reg, win_next;
    logic             v3_reg, out_valid_reg, last_reg, div_pend_reg;
    logic [SUM_W-1:0] out_value_reg;
    bfws_tag_t        t3_reg;
    logic             div_start, div_busy, div_done;
    logic [SUM_W-1:0] div_q;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_mem[{cmd.slot, cmd.x}] <= cmd.pixel;
        end
        old_pix_reg <= row_mem[{cmd.slot, cmd.x}];
        cs_rd_reg <= col_mem[cmd.x];
        c1_reg <= cmd;
        t1_reg <= tag;
        if (v2_reg) begin
            col_mem[c2_reg.x] <= cs_reg;
        end
        back_rd_reg <= col_mem[c1_reg.x_back];
    end

    always_comb begin
        if (c1_reg.first_row) begin
            cs_next = CS_W'(c1_reg.pixel);
        end else if (c1_reg.in_box_rows) begin
            cs_next = cs_rd_reg + CS_W'(c1_reg.pixel);
        end else begin
            cs_next = cs_rd_reg + CS_W'(c1_reg.pixel) - CS_W'(old_pix_reg);
        end
        // Bypass a column sum being written the same cycle as it is read.
        if (v2_reg && c2_reg.x == c1_reg.x) begin
            if (c1_reg.first_row) begin
                cs_next = CS_W'(c1_reg.pixel);
            end else if (c1_reg.in_box_rows) begin
                cs_next = cs_reg + CS_W'(c1_reg.pixel);
            end else begin
                cs_next = cs_reg + CS_W'(c1_reg.pixel) - CS_W'(old_pix_reg);
            end
        end
        if (c2_reg.first_col) begin
            win_next = SUM_W'(cs_reg);
        end else if (c2_reg.in_box_cols) begin
            win_next = win_reg + SUM_W'(cs_reg);
        end else begin
            win_next = win_reg + SUM_W'(cs_reg) - SUM_W'(back_rd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            div_pend_reg <= 1'b0;
            win_reg <= '0;
        end else begin
            v1_reg <= cmd.load;
            v2_reg <= v1_reg;
            v3_reg <= 1'b0;
            if (v2_reg) begin
                win_reg <= win_next;
                v3_reg <= t2_reg.emit;
            end else if (cmd.restart) begin
                win_reg <= '0;
            end
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (v3_reg && !t3_reg.scale) begin
                out_valid_reg <= 1'b1;
            end
            if (div_start) begin
                div_pend_reg <= 1'b1;
            end
            if (div_done) begin
                div_pend_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
        end
        cs_reg <= cs_next;
        c2_reg <= c1_reg;
        t2_reg <= t1_reg;
        t3_reg <= t2_reg;
        if (v3_reg && !t3_reg.scale) begin
            out_value_reg <= win_reg;
        end else if (div_done) begin
            out_value_reg <= div_q;
        end
        if (v3_reg) begin
            last_reg <= t3_reg.last;
        end
    end

    assign div_start = v3_reg && t3_reg.scale;

    bfws_divider u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(div_start),
        .dividend(win_reg),
        .box(t3_reg.box),
        .busy(div_busy),
        .done(div_done),
        .quotient(div_q)
    );

    assign busy = v1_reg | v2_reg | v3_reg | div_busy | div_pend_reg | out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_value = out_value_reg;
    assign m_last = last_reg;
endmodule

// ----- hdl/bfws_ctrl.sv -----
// Controller: configuration registers, frame position and item sequencing.
// Depends on bfws_pkg.
module bfws_ctrl
    import bfws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [12:0]      cfg_data,
    input  logic             s_tvalid,
    input  logic [PIX_W-1:0] s_pixel,
    output logic             s_tready,
    input  logic             dp_busy,
    output bfws_cmd_t        cmd,
    output bfws_tag_t        tag
);
    typedef enum logic {ST_IDLE, ST_WAIT} state_t;

    state_t           state_reg, state_next;
    logic [9:0]       ow_reg;
    logic [12:0]      oh_reg;
    logic [BOX_W-1:0] box_cfg_reg;
    logic             scale_reg;
    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BOX_W-1:0] b;
    logic [10:0]      w, ow_lim;
    logic [13:0]      h, oh_lim;
    logic [COL_W-1:0] xc;
    logic [ROW_W-1:0] yc;
    logic [SLOT_W-1:0] sc;
    logic             wrap, last, accept;

    always_comb begin
        b = (box_cfg_reg == '0) ? BOX_W'(1) : box_cfg_reg;
        if (b > BOX_W'(MAX_BOX)) b = BOX_W'(MAX_BOX);
        ow_lim = 11'(ow_reg == '0 ? 10'd1 : ow_reg);
        if (ow_lim > 11'(MAX_LINE) - 11'(b) + 11'd1) ow_lim = 11'(MAX_LINE) - 11'(b) + 11'd1;
        oh_lim = 14'(oh_reg == '0 ? 13'd1 : oh_reg);
        if (oh_lim > 14'd8192 - 14'(b)) oh_lim = 14'd8192 - 14'(b);
        w = ow_lim + 11'(b) - 11'd1;
        h = oh_lim + 14'(b) - 14'd1;
        wrap = (11'(x_reg) >= w) || (14'(y_reg) >= h);
        xc = wrap ? '0 : x_reg;
        yc = wrap ? '0 : y_reg;
        sc = wrap ? '0 : slot_reg;
        last = (11'(xc) == w - 11'd1) && (14'(yc) == h - 14'd1);
        accept = s_tvalid && s_tready;

        cmd.load = accept;
        cmd.pixel = s_pixel;
        cmd.x = xc;
        cmd.slot = sc;
        cmd.first_row = (yc == '0);
        cmd.in_box_rows = (14'(yc) < 14'(b));
        cmd.first_col = (xc == '0);
        cmd.in_box_cols = (11'(xc) < 11'(b));
        cmd.x_back = xc - COL_W'(b);
        cmd.restart = cfg_wr_en;
        tag.emit = (14'(yc) + 14'd1 >= 14'(b)) && (11'(xc) + 11'd1 >= 11'(b));
        tag.last = last;
        tag.scale = scale_reg;
        tag.box = b;

        x_next = xc;
        y_next = yc;
        slot_next = sc;
        if (11'(xc) + 11'd1 < w) begin
            x_next = xc + 1'b1;
        end else begin
            x_next = '0;
            y_next = last ? '0 : yc + 1'b1;
            slot_next = (last || 5'(sc) + 5'd1 >= b) ? '0 : sc + 1'b1;
        end
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_WAIT;
            ST_WAIT: if (!dp_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ow_reg <= 10'd1;
            oh_reg <= 13'd1;
            box_cfg_reg <= BOX_W'(1);
            scale_reg <= 1'b0;
            x_reg <= '0;
            y_reg <= '0;
            slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_OUT_WIDTH: ow_reg <= cfg_data[9:0];
                    REG_OUT_HEIGHT: oh_reg <= cfg_data;
                    REG_BOX_SIZE: box_cfg_reg <= cfg_data[BOX_W-1:0];
                    REG_SCALE: scale_reg <= cfg_data[0];
                    default: ;
                endcase
                x_reg <= '0;
                y_reg <= '0;
                slot_reg <= '0;
            end else if (accept) begin
                x_reg <= x_next;
                y_reg <= y_next;
                slot_reg <= slot_next;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready) else $error("item taken while busy");
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> 5'(sc) < b) else $error("row slot out of range");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> 11'(xc) < w) else $error("column out of range");
`endif
endmodule
